// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the tone sequencer datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NTTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication
`define NTTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== design/ntts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntts_pkg
// types, constants and lookup functions of the note tab tone sequencer
// ----------------------------------------------------------------------------
package ntts_pkg;

   localparam int ByteW     = 8;
   localparam int WholeW    = 16;
   localparam int OctW      = 4;
   localparam int IdxW      = 4;
   localparam int BaseW     = 15;
   localparam int PitchW    = 30;
   localparam int ClockDivW = 21;
   localparam int DivisorW  = 16;
   localparam int DurW      = 17;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 16;
   localparam int RspDataW  = 40;
   localparam int SelW      = 2;

   localparam logic [ClockDivW-1:0] ClockHz = 21'd1193180;
   localparam logic [DurW-1:0]      GapMs   = 17'd20;

   localparam logic [WholeW-1:0] WholeReset = 16'd2000;
   localparam logic [OctW-1:0]   TopReset   = 4'd9;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegWholeNote = 2'd0;
   localparam logic [CsrIdxW-1:0] RegTopOctave = 2'd1;

   // result selection codes
   localparam logic [SelW-1:0] SelGap  = 2'd0;
   localparam logic [SelW-1:0] SelRest = 2'd1;
   localparam logic [SelW-1:0] SelTone = 2'd2;

   localparam logic [ByteW-1:0] ChCaret = 8'h5E;
   localparam logic [ByteW-1:0] ChDot   = 8'h2E;
   localparam logic [ByteW-1:0] ChZero  = 8'h30;
   localparam logic [ByteW-1:0] ChNine  = 8'h39;

   typedef struct packed {
      logic lead_gap;
      logic rest;
      logic tone;
      logic tail_gap;
   } ntts_plan_type;

   typedef struct packed {
      logic            capture;
      logic            update;
      logic            div_start;
      logic            load;
      logic [SelW-1:0] sel;
      logic            last;
   } ntts_cmd_type;

   typedef struct packed {
      ntts_plan_type plan;
      logic          div_done;
      logic          out_free;
   } ntts_status_type;

   // {hit, index}
   function automatic logic [IdxW:0] letter_lookup(input logic [ByteW-1:0] b);
      logic [IdxW:0] r;
      case (b)
         8'h61:   r = {1'b1, 4'd0};
         8'h41:   r = {1'b1, 4'd1};
         8'h62:   r = {1'b1, 4'd2};
         8'h63:   r = {1'b1, 4'd3};
         8'h43:   r = {1'b1, 4'd4};
         8'h64:   r = {1'b1, 4'd5};
         8'h44:   r = {1'b1, 4'd6};
         8'h65:   r = {1'b1, 4'd7};
         8'h66:   r = {1'b1, 4'd8};
         8'h46:   r = {1'b1, 4'd9};
         8'h67:   r = {1'b1, 4'd10};
         8'h47:   r = {1'b1, 4'd11};
         default: r = {1'b0, 4'd0};
      endcase
      return r;
   endfunction

   function automatic logic [BaseW-1:0] base_pitch(input logic [IdxW-1:0] idx);
      logic [BaseW-1:0] p;
      case (idx)
         4'd1:    p = 15'd29833;
         4'd2:    p = 15'd31608;
         4'd3:    p = 15'd16744;
         4'd4:    p = 15'd17739;
         4'd5:    p = 15'd18793;
         4'd6:    p = 15'd19912;
         4'd7:    p = 15'd21096;
         4'd8:    p = 15'd22350;
         4'd9:    p = 15'd23680;
         4'd10:   p = 15'd25088;
         4'd11:   p = 15'd26579;
         default: p = 15'd28160;
      endcase
      return p;
   endfunction

endpackage

// ===== design/ntts_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntts_divider
// restoring divider, timer clock over pitch, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ntts_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ntts_pkg::PitchW-1:0]     den,
   output logic                            busy,
   output logic [ntts_pkg::DivisorW-1:0]   quotient
);

   localparam int CountW = $clog2(ntts_pkg::ClockDivW + 1);

   logic                              busy_ff, busy_in;
   logic [CountW-1:0]                 cnt_ff, cnt_in;
   logic [ntts_pkg::PitchW-1:0]       rem_ff, rem_in;
   logic [ntts_pkg::PitchW-1:0]       den_ff, den_in;
   logic [ntts_pkg::ClockDivW-1:0]    quo_ff, quo_in;

   logic [ntts_pkg::PitchW:0] trial;
   logic [ntts_pkg::PitchW:0] diff;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[ntts_pkg::ClockDivW-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         quo_in  = ntts_pkg::ClockHz;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ntts_pkg::PitchW-1:0] : trial[ntts_pkg::PitchW-1:0];
         quo_in = {quo_ff[ntts_pkg::ClockDivW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CountW'(ntts_pkg::ClockDivW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff[ntts_pkg::DivisorW-1:0];

endmodule

// ===== design/ntts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntts_datapath
// settings, token registers, byte decode, pitch and duration, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntts_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ntts_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [ntts_pkg::CsrDataW-1:0]      csr_data,
   input  logic [ntts_pkg::ByteW-1:0]         req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ntts_pkg::RspDataW-1:0]      rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,
   input  ntts_pkg::ntts_cmd_type             cmd,
   output ntts_pkg::ntts_status_type          status
);

   logic [ntts_pkg::WholeW-1:0] whole_ff, whole_in;
   logic [ntts_pkg::OctW-1:0]   top_ff, top_in;

   logic [ntts_pkg::ByteW-1:0]  byte_ff;
   logic                        fin_ff;

   logic [1:0]                  pos_ff, pos_in;
   logic [ntts_pkg::IdxW-1:0]   letter_ff, letter_in;
   logic [ntts_pkg::OctW-1:0]   oct_ff, oct_in;
   logic [ntts_pkg::OctW-1:0]   len_ff, len_in;
   logic                        gap_ff, gap_in;
   logic                        pzero_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [ntts_pkg::DivisorW-1:0] rsp_div_ff, rsp_div_in;
   logic [ntts_pkg::DurW-1:0]     rsp_dur_ff, rsp_dur_in;
   logic                          rsp_err_ff, rsp_err_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [ntts_pkg::IdxW:0]       lk;
   logic                          is_letter;
   logic                          is_digit;
   logic [3:0]                    digit_or_zero;
   logic [ntts_pkg::PitchW-1:0]   base_wide;
   logic [ntts_pkg::PitchW-1:0]   pitch;
   logic [ntts_pkg::WholeW-1:0]   note_base;
   logic [ntts_pkg::DurW-1:0]     tone_dur;
   logic [ntts_pkg::DurW-1:0]     rest_dur;
   logic                          div_busy;
   logic [ntts_pkg::DivisorW-1:0] quotient;
   logic                          out_free;

   assign csr_ready = 1'b1;

   // byte decode
   assign lk            = ntts_pkg::letter_lookup(byte_ff);
   assign is_letter     = lk[ntts_pkg::IdxW];
   assign is_digit      = (byte_ff >= ntts_pkg::ChZero) && (byte_ff <= ntts_pkg::ChNine);
   // low nibble of an ascii digit is its value
   assign digit_or_zero = is_digit ? byte_ff[3:0] : 4'd0;

   assign status.plan.lead_gap = (pos_ff == 2'd0) && gap_ff && (byte_ff != ntts_pkg::ChCaret);
   assign status.plan.rest     = (pos_ff == 2'd0) && is_digit;
   assign status.plan.tone     = (pos_ff == 2'd3);
   assign status.plan.tail_gap = (pos_ff == 2'd3) && fin_ff;
   assign status.div_done      = !div_busy;
   assign status.out_free      = out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // octave shift of the base pitch
   assign base_wide = {{(ntts_pkg::PitchW - ntts_pkg::BaseW){1'b0}},
                       ntts_pkg::base_pitch(letter_ff)};
   always_comb begin
      if (top_ff >= oct_ff) begin
         pitch = base_wide >> (top_ff - oct_ff);
      end else begin
         pitch = base_wide << (oct_ff - top_ff);
      end
   end

   assign note_base = whole_ff >> len_ff;
   assign tone_dur  = (byte_ff == ntts_pkg::ChDot)
                    ? ({1'b0, note_base} + {2'b00, note_base[ntts_pkg::WholeW-1:1]})
                    : {1'b0, note_base};
   assign rest_dur  = {1'b0, whole_ff >> byte_ff[3:0]};

   ntts_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .den      (pitch),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // settings
   always_comb begin
      whole_in = whole_ff;
      top_in   = top_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ntts_pkg::RegWholeNote: whole_in = csr_data;
            ntts_pkg::RegTopOctave: top_in   = csr_data[ntts_pkg::OctW-1:0];
            default: ;
         endcase
      end
   end

   // token state
   always_comb begin
      pos_in    = pos_ff;
      letter_in = letter_ff;
      oct_in    = oct_ff;
      len_in    = len_ff;
      gap_in    = gap_ff;
      if (cmd.update) begin
         case (pos_ff)
            2'd0: begin
               gap_in = 1'b0;
               if (is_letter) begin
                  letter_in = lk[ntts_pkg::IdxW-1:0];
                  pos_in    = 2'd1;
               end
            end
            2'd1: begin
               oct_in = digit_or_zero;
               pos_in = 2'd2;
            end
            2'd2: begin
               len_in = digit_or_zero;
               pos_in = 2'd3;
            end
            default: begin
               pos_in = 2'd0;
               gap_in = !fin_ff;
            end
         endcase
         // last byte of a melody drops any unfinished token
         if (fin_ff) begin
            pos_in = 2'd0;
            gap_in = 1'b0;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_div_in   = rsp_div_ff;
      rsp_dur_in   = rsp_dur_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.last;
         case (cmd.sel)
            ntts_pkg::SelRest: begin
               rsp_kind_in = 1'b1;
               rsp_div_in  = '0;
               rsp_dur_in  = rest_dur;
               rsp_err_in  = 1'b0;
            end
            ntts_pkg::SelTone: begin
               rsp_kind_in = 1'b0;
               rsp_div_in  = pzero_ff ? '0 : quotient;
               rsp_dur_in  = tone_dur;
               rsp_err_in  = pzero_ff;
            end
            default: begin
               rsp_kind_in = 1'b1;
               rsp_div_in  = '0;
               rsp_dur_in  = ntts_pkg::GapMs;
               rsp_err_in  = 1'b0;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff     <= ntts_pkg::WholeReset;
         top_ff       <= ntts_pkg::TopReset;
         pos_ff       <= '0;
         letter_ff    <= '0;
         oct_ff       <= '0;
         len_ff       <= '0;
         gap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         whole_ff     <= whole_in;
         top_ff       <= top_in;
         pos_ff       <= pos_in;
         letter_ff    <= letter_in;
         oct_ff       <= oct_in;
         len_ff       <= len_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.capture) begin
         byte_ff <= req_tdata;
         fin_ff  <= req_tlast;
      end
      if (cmd.div_start) begin
         pzero_ff <= (pitch == '0);
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_div_ff  <= rsp_div_in;
      rsp_dur_ff  <= rsp_dur_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(ntts_pkg::RspDataW - ntts_pkg::DivisorW - ntts_pkg::DurW - 1){1'b0}},
                        rsp_err_ff, rsp_dur_ff, rsp_div_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_kind_ff;

   `NTTS_ASSERT_IMP(a_load_free, clock, reset, cmd.load, out_free)
   `NTTS_ASSERT_IMP(a_start_idle, clock, reset, cmd.div_start, !div_busy)
   `NTTS_ASSERT_NEXT(a_start_busy, clock, reset, cmd.div_start, div_busy)
   `NTTS_ASSERT_IMP(a_tone_done, clock, reset, cmd.load && (cmd.sel == ntts_pkg::SelTone), !div_busy)

endmodule

// ===== design/ntts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntts_ctrl
// sequencer: takes a byte, decides its results, issues them one at a time
// ----------------------------------------------------------------------------
module ntts_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  ntts_pkg::ntts_status_type  status,
   output ntts_pkg::ntts_cmd_type     cmd
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StDecode = 3'd1;
   localparam logic [2:0] StLead   = 3'd2;
   localparam logic [2:0] StRest   = 3'd3;
   localparam logic [2:0] StDiv    = 3'd4;
   localparam logic [2:0] StTone   = 3'd5;
   localparam logic [2:0] StTail   = 3'd6;

   logic [2:0]              state_ff, state_in;
   ntts_pkg::ntts_plan_type plan_ff, plan_in;

   assign req_tready = (state_ff == StIdle);

   always_comb begin
      state_in = state_ff;
      plan_in  = plan_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = StDecode;
            end
         end
         StDecode: begin
            cmd.update    = 1'b1;
            plan_in       = status.plan;
            cmd.div_start = status.plan.tone;
            if (status.plan.lead_gap) begin
               state_in = StLead;
            end else if (status.plan.rest) begin
               state_in = StRest;
            end else if (status.plan.tone) begin
               state_in = StDiv;
            end else begin
               state_in = StIdle;
            end
         end
         StLead: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = ntts_pkg::SelGap;
               cmd.last = !plan_ff.rest;
               state_in = plan_ff.rest ? StRest : StIdle;
            end
         end
         StRest: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = ntts_pkg::SelRest;
               cmd.last = 1'b1;
               state_in = StIdle;
            end
         end
         StDiv: begin
            if (status.div_done) begin
               state_in = StTone;
            end
         end
         StTone: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = ntts_pkg::SelTone;
               cmd.last = !plan_ff.tail_gap;
               state_in = plan_ff.tail_gap ? StTail : StIdle;
            end
         end
         StTail: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = ntts_pkg::SelGap;
               cmd.last = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         plan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         plan_ff  <= plan_in;
      end
   end

endmodule

// ===== design/note_tab_tone_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_tab_tone_sequencer_top
// melody text in, tone and silence descriptors out
// ----------------------------------------------------------------------------
// req channel: one melody character per item, req_tlast marks the final one.
// rsp channel: one tone or silence per item; rsp_tuser is the kind (1 silence),
// rsp_tlast marks the last result caused by one character.
// csr channel: index 0 whole-note length in ms, index 1 top octave; always
// ready; the user must write it only while idle, the block does not enforce it.
// a leading gap, or a rest with no gap before it, is presented once its
// character is taken and decoded; a tone appears after its separator once the
// 21-step restoring divider that forms the timer divisor is done, then its gap.
// a new character is taken only when every result of the previous one has
// been loaded into the result register.
// reset: token state clears, settings return to 2000 ms and octave 9, no
// result is pending.
// a stalled rsp holds the result register; the next character is still taken
// and stops only when it needs the occupied result register.
// ----------------------------------------------------------------------------
module note_tab_tone_sequencer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ntts_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [ntts_pkg::CsrDataW-1:0]      csr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ntts_pkg::ByteW-1:0]         req_tdata,   // [7:0] tab_byte
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] divisor, [32:16] duration_ms, [33] pitch_error, [39:34] zero
   output logic [ntts_pkg::RspDataW-1:0]      rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser    // [0] kind
);

   ntts_pkg::ntts_cmd_type    cmd;
   ntts_pkg::ntts_status_type status;

   ntts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ntts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
